### design/arm64_dp_immediate_decoder_unit_assert.svh
// Assertion macros for the data-processing immediate decoder
`ifndef ARM64_DP_IMMEDIATE_DECODER_UNIT_ASSERT_SVH
`define ARM64_DP_IMMEDIATE_DECODER_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define DPI_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("dpi check failed");

// Next-cycle implication
`define DPI_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("dpi check failed");

`endif

### design/dpi_pkg.sv
// ----------------------------------------------------------------------------
// dpi_pkg
// Operation codes and result type for the data-processing immediate decoder.
// ----------------------------------------------------------------------------
package dpi_pkg;

  typedef enum logic [5:0] {
    OP_ADR = 6'd0, OP_ADRP, OP_MOV_SP, OP_ADD, OP_CMN, OP_ADDS, OP_SUB, OP_CMP,
    OP_SUBS, OP_ADDG, OP_SUBG, OP_AND, OP_MOV_BM, OP_ORR, OP_EOR, OP_TST,
    OP_ANDS, OP_MOV_W, OP_MOVN, OP_MOVZ, OP_MOVK, OP_ASR, OP_SBFIZ, OP_SBFX,
    OP_SXTB, OP_SXTH, OP_SXTW, OP_SBFM, OP_BFC, OP_BFI, OP_BFXIL, OP_BFM,
    OP_LSL, OP_LSR, OP_UBFIZ, OP_UBFX, OP_UXTB, OP_UXTH, OP_UBFM
  } dpi_op_e;

  typedef struct packed {
    logic        undef;
    dpi_op_e     op;
    logic        is64;
    logic [4:0]  rd;
    logic [4:0]  rn;
    logic [63:0] val;
    logic [6:0]  aux;
    logic [6:0]  wid;
  } dpi_res_t;

endpackage

### design/dpi_decode.sv
// ----------------------------------------------------------------------------
// dpi_decode
// Combinational decode of one data-processing immediate instruction word.
// ----------------------------------------------------------------------------
module dpi_decode
  import dpi_pkg::*;
(
  input  logic [31:0] instr_i,
  input  logic [63:0] pc_i,
  output dpi_res_t    res_o
);

  logic        sf, nb;
  logic [1:0]  opc, hw;
  logic [5:0]  r, s;
  logic [4:0]  rd, rn;
  logic [11:0] k12;
  logic [15:0] k16;
  logic [2:0]  cls;

  assign sf  = instr_i[31];
  assign opc = instr_i[30:29];
  assign nb  = instr_i[22];
  assign hw  = instr_i[22:21];
  assign r   = instr_i[21:16];
  assign s   = instr_i[15:10];
  assign rn  = instr_i[9:5];
  assign rd  = instr_i[4:0];
  assign k12 = instr_i[21:10];
  assign k16 = instr_i[20:5];
  assign cls = instr_i[25:23];

  // pc-relative targets
  logic [63:0] adr_t, adrp_t;
  logic [20:0] raw21;
  assign raw21  = {instr_i[23:5], instr_i[30:29]};
  assign adr_t  = pc_i + {{43{raw21[20]}}, raw21};
  assign adrp_t = {pc_i[63:12], 12'd0} + {{31{raw21[20]}}, raw21, 12'd0};

  // bitmask expansion
  logic [6:0]  comb;
  logic [2:0]  lg;
  logic [5:0]  lev, se, re;
  logic        bm_ok;
  logic [63:0] elem, rot, mask;
  logic [6:0]  esz;

  always_comb begin
    comb = {nb, ~s};
    lg = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (comb[i]) lg = 3'(i);
    end
    lev   = 6'((7'd1 << lg) - 7'd1);
    bm_ok = (lg != 3'd0) && ((s & lev) != lev);
    se    = s & lev;
    re    = r & lev;
    esz   = 7'd1 << lg;
    elem  = (64'd2 << se) - 64'd1;
    rot   = elem;
    if (re != 6'd0) rot = (elem >> re) | (elem << (esz - {1'b0, re}));
    case (lg)
      3'd1:    mask = {32{rot[1:0]}};
      3'd2:    mask = {16{rot[3:0]}};
      3'd3:    mask = {8{rot[7:0]}};
      3'd4:    mask = {4{rot[15:0]}};
      3'd5:    mask = {2{rot[31:0]}};
      default: mask = rot;
    endcase
    if (!sf) mask[63:32] = 32'd0;
  end

  // move-wide preference for orr alias
  logic wide_pref;
  always_comb begin
    wide_pref = 1'b0;
    if (!((sf && !nb) || (!sf && (nb || s[5])))) begin
      if (s < 6'd16)
        wide_pref = ((5'd16 - {1'b0, r[3:0]}) & 5'd15) <= (5'd15 - {1'b0, s[4:0]});
      else if ({1'b0, s} >= (sf ? 7'd49 : 7'd17))
        wide_pref = {3'd0, r[3:0]} <= ({1'b0, s} - (sf ? 7'd49 : 7'd17));
    end
  end

  // move wide
  logic [63:0] placed, inv;
  logic        plain;
  assign placed = {48'd0, k16} << {hw, 4'd0};
  assign inv    = sf ? ~placed : {32'd0, ~placed[31:0]};
  assign plain  = !(k16 == 16'd0 && hw != 2'd0);

  // bitfield helpers
  logic [6:0] size, top, r7, s7, negr, s1, slr;
  logic       xp_s, xp_u;
  assign size = sf ? 7'd64 : 7'd32;
  assign top  = size - 7'd1;
  assign r7   = {1'b0, r};
  assign s7   = {1'b0, s};
  assign negr = size - r7;
  assign s1   = s7 + 7'd1;
  assign slr  = s7 - r7 + 7'd1;

  always_comb begin
    xp_s = !(s7 < r7) && (s7 != top);
    xp_u = xp_s;
    if (r == 6'd0) begin
      if (!sf && (s == 6'd7 || s == 6'd15)) begin
        xp_s = 1'b0;
        xp_u = 1'b0;
      end
      if (sf && (s == 6'd7 || s == 6'd15 || s == 6'd31)) xp_s = 1'b0;
    end
  end

  always_comb begin
    res_o       = '0;
    res_o.is64  = sf;
    res_o.rd    = rd;
    res_o.rn    = rn;
    res_o.op    = OP_ADR;
    unique case (cls)
      3'b000, 3'b001: begin
        res_o.is64 = 1'b1;
        res_o.rn   = 5'd0;
        res_o.op   = sf ? OP_ADRP : OP_ADR;
        res_o.val  = sf ? adrp_t : adr_t;
      end
      3'b010: begin
        res_o.val = {52'd0, k12};
        res_o.aux = nb ? 7'd12 : 7'd0;
        case (opc)
          2'b00: res_o.op = (!nb && k12 == 12'd0 && (rd == 5'd31 || rn == 5'd31))
                            ? OP_MOV_SP : OP_ADD;
          2'b01: res_o.op = (rd == 5'd31) ? OP_CMN : OP_ADDS;
          2'b10: res_o.op = OP_SUB;
          default: res_o.op = (rd == 5'd31) ? OP_CMP : OP_SUBS;
        endcase
      end
      3'b011: begin
        res_o.undef = !sf || opc[0] || nb;
        res_o.is64  = 1'b1;
        res_o.op    = opc[1] ? OP_SUBG : OP_ADDG;
        res_o.val   = {54'd0, instr_i[21:16], 4'd0};
        res_o.aux   = {3'd0, instr_i[13:10]};
      end
      3'b100: begin
        res_o.undef = (!sf && nb) || !bm_ok;
        res_o.val   = mask;
        case (opc)
          2'b00: res_o.op = OP_AND;
          2'b01: res_o.op = (rn == 5'd31 && !wide_pref) ? OP_MOV_BM : OP_ORR;
          2'b10: res_o.op = OP_EOR;
          default: res_o.op = (rd == 5'd31) ? OP_TST : OP_ANDS;
        endcase
      end
      3'b101: begin
        res_o.undef = (opc == 2'b01) || (!sf && hw[1]);
        res_o.rn    = 5'd0;
        res_o.val   = {48'd0, k16};
        res_o.aux   = {1'b0, hw, 4'd0};
        case (opc)
          2'b00: begin
            if (plain && !(!sf && k16 == 16'hffff)) begin
              res_o.op = OP_MOV_W; res_o.val = inv; res_o.aux = '0;
            end else res_o.op = OP_MOVN;
          end
          2'b10: begin
            if (plain) begin
              res_o.op = OP_MOV_W; res_o.val = placed; res_o.aux = '0;
            end else res_o.op = OP_MOVZ;
          end
          default: res_o.op = OP_MOVK;
        endcase
      end
      3'b110: begin
        res_o.undef = (opc == 2'b11) || (nb != sf) || (!sf && (r[5] || s[5]));
        case (opc)
          2'b00: begin
            if (s7 == top) begin
              res_o.op = OP_ASR; res_o.aux = r7;
            end else if (s7 < r7) begin
              res_o.op = OP_SBFIZ; res_o.aux = negr; res_o.wid = s1;
            end else if (xp_s) begin
              res_o.op = OP_SBFX; res_o.aux = r7; res_o.wid = slr;
            end else if (r == 6'd0 && s == 6'd7) res_o.op = OP_SXTB;
            else if (r == 6'd0 && s == 6'd15) res_o.op = OP_SXTH;
            else if (r == 6'd0 && s == 6'd31) res_o.op = OP_SXTW;
            else begin
              res_o.op = OP_SBFM; res_o.aux = r7; res_o.wid = s7;
            end
          end
          2'b01: begin
            if (s7 < r7) begin
              res_o.op = (rn == 5'd31) ? OP_BFC : OP_BFI;
              res_o.aux = negr; res_o.wid = s1;
            end else begin
              res_o.op = OP_BFXIL; res_o.aux = r7; res_o.wid = slr;
            end
          end
          default: begin
            if (s7 != top && s1 == r7) begin
              res_o.op = OP_LSL; res_o.aux = top - s7;
            end else if (s7 == top) begin
              res_o.op = OP_LSR; res_o.aux = r7;
            end else if (s7 < r7) begin
              res_o.op = OP_UBFIZ; res_o.aux = negr; res_o.wid = s1;
            end else if (xp_u) begin
              res_o.op = OP_UBFX; res_o.aux = r7; res_o.wid = slr;
            end else if (r == 6'd0 && s == 6'd7) res_o.op = OP_UXTB;
            else if (r == 6'd0 && s == 6'd15) res_o.op = OP_UXTH;
            else begin
              res_o.op = OP_UBFM; res_o.aux = r7; res_o.wid = s7;
            end
          end
        endcase
      end
      default: res_o.undef = 1'b1;
    endcase
    if (res_o.undef) begin
      res_o       = '0;
      res_o.undef = 1'b1;
    end
  end

endmodule

### design/arm64_dp_immediate_decoder_unit.sv
// ----------------------------------------------------------------------------
// arm64_dp_immediate_decoder_unit
// AArch64 data-processing immediate decode, one item per cycle when not stalled.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  in      | in_valid_i, in_stall_o, fields   | instruction word and pc in
//  out     | out_valid_o, out_stall_i, fields | decoded result out
//
// One item per cycle while out_stall_i is low; path: input reg, then result reg.
// Input register feeds the decode logic, whose output fills the result reg.
// rst_ni clears the valid flags only; payload registers are not reset.
// A stalled result holds; the pipe keeps moving while its last stage is free.
// ----------------------------------------------------------------------------
`include "arm64_dp_immediate_decoder_unit_assert.svh"

module arm64_dp_immediate_decoder_unit
  import dpi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] instr_word_i,
  input  logic [63:0] pc_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        undefined_o,
  output logic [5:0]  op_code_o,
  output logic        is_64_o,
  output logic [4:0]  dest_reg_o,
  output logic [4:0]  src_reg_o,
  output logic [63:0] imm_value_o,
  output logic [6:0]  aux_imm_o,
  output logic [6:0]  field_width_o
);

  logic        s1_vld_q, s2_vld_q;
  logic [31:0] instr_q;
  logic [63:0] pc_q;
  dpi_res_t    res_d, res_q;
  logic        s2_adv, s1_adv;

  // result stage moves when empty or being taken; input stage follows
  assign s2_adv     = !s2_vld_q || !out_stall_i;
  assign s1_adv     = !s1_vld_q || s2_adv;
  assign in_stall_o = !s1_adv;

  dpi_decode u_dec (
    .instr_i (instr_q),
    .pc_i    (pc_q),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (s1_adv) s1_vld_q <= in_valid_i;
      if (s2_adv) s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      instr_q <= instr_word_i;
      pc_q    <= pc_i;
    end
    if (s2_adv && s1_vld_q) res_q <= res_d;
  end

  assign out_valid_o   = s2_vld_q;
  assign undefined_o   = res_q.undef;
  assign op_code_o     = res_q.op;
  assign is_64_o       = res_q.is64;
  assign dest_reg_o    = res_q.rd;
  assign src_reg_o     = res_q.rn;
  assign imm_value_o   = res_q.val;
  assign aux_imm_o     = res_q.aux;
  assign field_width_o = res_q.wid;

  `DPI_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(res_q))
  `DPI_ASSERT_IMP(a_undef_zero, clk_i, rst_ni, out_valid_o && undefined_o, imm_value_o == 64'd0 && op_code_o == OP_ADR)
  `DPI_ASSERT_IMP(a_stall, clk_i, rst_ni, in_stall_o, s1_vld_q && s2_vld_q && out_stall_i)

endmodule
